@@ hw/rtl/assert_macros.svh @@
// assertion helpers included by can_signal_extract_scale
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/csx_pkg.sv @@
// ----------------------------------------------------------------------------
// csx_pkg
// Types and constants of the CAN signal extract and scale block.
// ----------------------------------------------------------------------------
package csx_pkg;

	localparam int MAX_PAYLOAD_BYTES_DEF = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int ERR_W       = 2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_START_BIT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_LENGTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IS_SIGNED  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET     = 3'd5;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DEF   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_SHORT = 2'd2;

	// byte order
	localparam logic ORDER_INTEL    = 1'b0;
	localparam logic ORDER_MOTOROLA = 1'b1;

	localparam logic [63:0] PHYS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

endpackage

@@ hw/rtl/can_signal_extract_scale.sv @@
// ----------------------------------------------------------------------------
// can_signal_extract_scale
// Extracts one configured Intel or Motorola signal from a CAN payload and
// scales it to a saturated Q48.16 physical value.
//
//   channel   handshake        payload
//   -------   --------------   -----------------------------------------------
//   input     start / busy     payload_bytes, payload_length
//   config    cfg_we           cfg_index, cfg_data
//   result    done (strobe)    error_code, raw_value, physical_value, saturated
//
// one item per cycle; registers in order: input, extracted value, partial products, result
// datapath: input register, extraction shifter, split multiplier, final add
// busy stays low, the pipeline never stalls and results cannot be held off
// asynchronous reset clears the valid chain and loads the register defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module can_signal_extract_scale #(
	parameter int MAX_PAYLOAD_BYTES = csx_pkg::MAX_PAYLOAD_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [63:0]                   payload_bytes,
	input  logic [3:0]                    payload_length,
	input  logic                          cfg_we,
	input  logic [csx_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csx_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                          done,
	output logic [csx_pkg::ERR_W-1:0]     error_code,
	output logic [63:0]                   raw_value,
	output logic signed [63:0]            physical_value,
	output logic                          saturated
);
	import csx_pkg::*;

	localparam logic [3:0] MAX_LEN = 4'(MAX_PAYLOAD_BYTES);

	// configuration
	logic [5:0]         start_bit_q;
	logic [6:0]         bit_length_q;
	logic               byte_order_q;
	logic               is_signed_q;
	logic signed [31:0] scale_q;
	logic signed [63:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bit_q  <= 6'd0;
			bit_length_q <= 7'd8;
			byte_order_q <= ORDER_INTEL;
			is_signed_q  <= 1'b0;
			scale_q      <= 32'sd65536;
			offset_q     <= 64'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BIT:  start_bit_q  <= cfg_data[5:0];
				REG_BIT_LENGTH: bit_length_q <= cfg_data[6:0];
				REG_BYTE_ORDER: byte_order_q <= cfg_data[0];
				REG_IS_SIGNED:  is_signed_q  <= cfg_data[0];
				REG_SCALE:      scale_q      <= $signed(cfg_data[31:0]);
				REG_OFFSET:     offset_q     <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: input register
	logic        valid_s1;
	logic [63:0] data_s1;
	logic [3:0]  len_bytes_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			data_s1      <= payload_bytes;
			len_bytes_s1 <= (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
		end
	end

	// extraction
	logic [63:0]      swapped;
	logic             def_bad;
	logic [7:0]       intel_last;
	logic [5:0]       moto_first;
	logic [7:0]       moto_last;
	logic [7:0]       moto_shift;
	logic             short_pay;
	logic [63:0]      shifted;
	logic [63:0]      len_mask;
	logic [63:0]      raw_u;
	logic [6:0]       len_m1;
	logic             neg_c;
	logic [63:0]      raw_c;
	logic [ERR_W-1:0] err_c;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			swapped[8*k +: 8] = data_s1[8*(7-k) +: 8];
		end
		def_bad    = (bit_length_q == 7'd0) || (bit_length_q > 7'd64);
		intel_last = {2'b00, start_bit_q} + {1'b0, bit_length_q} - 8'd1;
		// motorola bits walk upward in big-endian numbering
		moto_first = {start_bit_q[5:3], ~start_bit_q[2:0]};
		moto_last  = {2'b00, moto_first} + {1'b0, bit_length_q} - 8'd1;
		moto_shift = 8'd64 - {2'b00, moto_first} - {1'b0, bit_length_q};
		if (byte_order_q == ORDER_INTEL) begin
			short_pay = intel_last[7:3] >= {1'b0, len_bytes_s1};
			shifted   = data_s1 >> start_bit_q;
		end else begin
			short_pay = moto_last[7:3] >= {1'b0, len_bytes_s1};
			shifted   = swapped >> moto_shift[5:0];
		end
		len_mask = bit_length_q[6] ? '1 : ((64'd1 << bit_length_q[5:0]) - 64'd1);
		raw_u    = shifted & len_mask;
		len_m1   = bit_length_q - 7'd1;
		neg_c    = is_signed_q && raw_u[len_m1[5:0]];
		raw_c    = neg_c ? (raw_u | ~len_mask) : raw_u;
		err_c    = ERR_OK;
		if (def_bad) begin
			err_c = ERR_DEF;
		end else if (short_pay) begin
			err_c = ERR_SHORT;
		end
		if (err_c != ERR_OK) begin
			raw_c = 64'd0;
			neg_c = 1'b0;
		end
	end

	// stage 2: extracted value
	logic             valid_s2;
	logic [63:0]      raw_s2;
	logic             neg_s2;
	logic [ERR_W-1:0] err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		raw_s2 <= raw_c;
		neg_s2 <= neg_c;
		err_s2 <= err_c;
	end

	// stage 3: partial products of the 65-bit raw value and the scale
	logic               valid_s3;
	logic [63:0]        raw_s3;
	logic [ERR_W-1:0]   err_s3;
	logic signed [64:0] p_lo_s3;
	logic signed [64:0] p_hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		raw_s3  <= raw_s2;
		err_s3  <= err_s2;
		p_lo_s3 <= $signed({1'b0, raw_s2[31:0]}) * scale_q;
		p_hi_s3 <= $signed({neg_s2, raw_s2[63:32]}) * scale_q;
	end

	// sum and saturation
	logic signed [97:0] sum_c;
	logic               ovf_c;
	logic [63:0]        phys_c;

	always_comb begin
		sum_c  = (98'(p_hi_s3) <<< 32) + 98'(p_lo_s3) + 98'(offset_q);
		ovf_c  = sum_c[97:63] != {35{sum_c[63]}};
		phys_c = ovf_c ? (sum_c[97] ? PHYS_MIN : PHYS_MAX) : sum_c[63:0];
	end

	// stage 4: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		error_code     <= err_s3;
		raw_value      <= raw_s3;
		physical_value <= (err_s3 == ERR_OK) ? $signed(phys_c) : 64'sd0;
		saturated      <= (err_s3 == ERR_OK) && ovf_c;
	end

	`ASSERT_NEXT(a_done_after_s3, clk, arst_n, valid_s3, done)
	`ASSERT_NEXT(a_no_done_without_s3, clk, arst_n, !valid_s3, !done)
	`ASSERT_CLK(a_error_zero_fields, clk, arst_n, !(done && error_code != ERR_OK) || (raw_value == 64'd0 && physical_value == 64'sd0 && !saturated))
	`ASSERT_CLK(a_sat_at_limit, clk, arst_n, !(done && saturated) || (physical_value == $signed(PHYS_MAX) || physical_value == $signed(PHYS_MIN)))

endmodule
